>>> src/tbrl_pkg.sv
// Shared types and constants for the token bucket rate limiter.
package tbrl_pkg;

    localparam int unsigned US_PER_SEC = 1000000;
    // 2^32 = FOLD_Q * 10^6 + FOLD_K
    localparam int unsigned FOLD_K     = 967296;
    localparam int unsigned FOLD_Q     = 4294;
    // floor(2^32 / 15625); 10^6 = 64 * 15625
    localparam int unsigned RECIP      = 274877;

    localparam int unsigned TIME_W   = 64;
    localparam int unsigned TOKEN_W  = 32;
    localparam int unsigned REM_W    = 20;
    localparam int unsigned GAIN_W   = 33;
    localparam int unsigned QUOT_W   = 46;

    typedef enum logic [1:0] {
        KIND_REFILL = 2'd0,
        KIND_TAKE   = 2'd1,
        KIND_INIT   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BACK  = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    localparam logic CFG_RATE   = 1'b0;
    localparam logic CFG_BUCKET = 1'b1;

    // Side information that rides along with the refill arithmetic.
    typedef struct packed {
        logic [1:0]         kind;
        logic [TOKEN_W-1:0] need;
        logic               back;    // refill with time going backwards
        logic               p_top;   // product sits in the top 2^20 of the range
        logic [REM_W-1:0]   p_low;   // low 20 bits of the product
    } t_tag;

endpackage

>>> src/tbrl_refill_pipe.sv
// Refill arithmetic pipeline: rate * elapsed mod 2^64, split by 10^6.
module tbrl_refill_pipe (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  tbrl_pkg::t_tag                        i_tag,
    input  logic [tbrl_pkg::TIME_W-1:0]           i_elapsed,
    input  logic [tbrl_pkg::TOKEN_W-1:0]          i_rate,
    output logic                                  o_vld,
    output tbrl_pkg::t_tag                        o_tag,
    output logic [tbrl_pkg::GAIN_W-1:0]           o_g0,
    output logic [tbrl_pkg::GAIN_W-1:0]           o_g1,
    output logic [tbrl_pkg::REM_W-1:0]            o_rem
);

    localparam int unsigned NSTG = 9;

    function automatic logic [tbrl_pkg::GAIN_W-1:0] sat_gain(
        input logic [tbrl_pkg::QUOT_W-1:0] v
    );
        logic [tbrl_pkg::GAIN_W-1:0] res;
        if (|v[tbrl_pkg::QUOT_W-1:32]) begin
            res = {1'b1, 32'd0};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    logic [NSTG-1:0]    r_vld;
    tbrl_pkg::t_tag     r_tag [NSTG];
    tbrl_pkg::t_tag     n_tag2;

    logic [63:0] r_pp0;
    logic [31:0] r_ehi;
    logic [31:0] w_hmul;
    logic [63:0] r_p;
    logic [51:0] r_x;
    logic [32:0] r_h4;
    logic [40:0] r_y;
    logic [32:0] r_h5;
    logic [32:0] r_z;
    logic [32:0] r_h6;
    logic [45:0] w_recip_prod;
    logic [13:0] r_qe;
    logic [32:0] r_z7;
    logic [45:0] r_base;
    logic [32:0] w_qe_mul;
    logic [20:0] r_zr;
    logic [13:0] r_qe8;
    logic [45:0] r_base8;
    logic        w_zc;
    logic [45:0] r_q;
    logic [19:0] r_r;
    logic [32:0] r_g0;
    logic [32:0] r_g1;
    logic [19:0] r_r10;

    assign w_hmul       = i_rate * r_ehi;  // only low word survives mod 2^64
    assign w_recip_prod = 46'(r_z[32:6]) * 46'(tbrl_pkg::RECIP);
    assign w_qe_mul     = 33'(r_qe) * 33'(tbrl_pkg::US_PER_SEC);
    assign w_zc         = (r_zr >= 21'(tbrl_pkg::US_PER_SEC));

    always_comb begin
        n_tag2       = r_tag[1];
        n_tag2.p_top = &r_p[63:20];
        n_tag2.p_low = r_p[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= n_tag2;
            for (int k = 3; k < NSTG; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            // low partial product
            r_pp0   <= 64'(i_rate) * 64'(i_elapsed[31:0]);
            r_ehi   <= i_elapsed[63:32];
            // full product, wrapped to 64 bits
            r_p     <= {r_pp0[63:32] + w_hmul, r_pp0[31:0]};
            // fold the high word: hi * 2^32 = hi * FOLD_Q * 1e6 + hi * FOLD_K
            r_x     <= 52'(r_p[63:32]) * 52'(tbrl_pkg::FOLD_K) + 52'(r_p[31:0]);
            r_h4    <= 33'(r_p[63:32]);
            r_y     <= 41'(r_x[51:32]) * 41'(tbrl_pkg::FOLD_K) + 41'(r_x[31:0]);
            r_h5    <= r_h4 + 33'(r_x[51:32]);
            r_z     <= 33'(r_y[40:32]) * 33'(tbrl_pkg::FOLD_K) + 33'(r_y[31:0]);
            r_h6    <= r_h5 + 33'(r_y[40:32]);
            // quotient estimate of z / 1e6, low by at most one
            r_qe    <= w_recip_prod[45:32];
            r_z7    <= r_z;
            r_base  <= 46'(r_h6) * 46'(tbrl_pkg::FOLD_Q);
            r_zr    <= 21'(r_z7 - w_qe_mul);
            r_qe8   <= r_qe;
            r_base8 <= r_base;
            // correction step
            r_q     <= r_base8 + 46'(r_qe8) + 46'(w_zc);
            r_r     <= w_zc ? 20'(r_zr - 21'(tbrl_pkg::US_PER_SEC)) : r_zr[19:0];
            // gain without and with a carry from the old remainder
            r_g0    <= sat_gain(r_q);
            r_g1    <= sat_gain(r_q + 46'd1);
            r_r10   <= r_r;
        end
    end

    assign o_vld = r_vld[NSTG-1];
    assign o_tag = r_tag[NSTG-1];
    assign o_g0  = r_g0;
    assign o_g1  = r_g1;
    assign o_rem = r_r10;

endmodule

>>> src/token_bucket_rate_limiter.sv
// Top level of the token bucket rate limiter.
//
// Requests enter on the s_axis channel: tuser carries the kind (refill at a
// timestamp, take tokens, init bucket), tdata carries now_us and need_tokens.
// Each request yields one result on m_axis: tuser is the status (ok, time
// went backwards, not enough tokens), tdata the token count after it.
// rate_per_sec and bucket_size are written on the cfg port while idle.
//
// Throughput is one transfer per cycle while the receiver keeps up. A transfer
// loads an input register, then nine pipeline stages form rate * elapsed mod
// 2^64 and split it by 10^6 (32x32 multiplies and constant folds), and a final
// stage applies the remainder carry, clamp or take against the live bucket
// state and loads the output register. last_time is tracked at the input, so
// back-to-back requests need no forwarding.
//
// Synchronous reset empties the pipeline, zeroes tokens, last_time and the
// remainder, and sets both registers to 1000. When the receiver stalls, the
// result holds; the pipeline keeps advancing while its last stage is empty
// and freezes as a whole only while a finished result waits there behind a
// stalled output register, which is the only time input is refused.
module token_bucket_rate_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [63:0] now_us, [95:64] need_tokens
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] tokens_left
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic [31:0] r_rate;
    logic [31:0] r_bucket;
    logic [63:0] r_last_time;
    logic [31:0] r_tokens;
    logic [19:0] r_rem;

    logic           r_s1_vld;
    tbrl_pkg::t_tag r_s1_tag;
    logic [63:0]    r_s1_elapsed;

    logic           w_en;
    logic           w_accept;
    logic           w_load;
    logic [63:0]    w_now;

    logic           w_pv;
    tbrl_pkg::t_tag w_ptag;
    logic [32:0]    w_g0;
    logic [32:0]    w_g1;
    logic [19:0]    w_prem;

    logic [20:0]    w_wrap_sum;
    logic           w_wrap;
    logic [20:0]    w_rsum;
    logic           w_rc;
    logic [19:0]    w_rem_nw;
    logic [32:0]    w_gain;
    logic [33:0]    w_sum;
    logic [31:0]    w_tok_ref;

    tbrl_pkg::t_status n_status;
    logic [31:0]       n_tokens;
    logic [19:0]       n_rem;

    logic              r_out_vld;
    tbrl_pkg::t_status r_out_status;
    logic [31:0]       r_out_tokens;

    // pipeline moves when the last stage is empty or can drain
    assign w_en          = !w_pv || !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;
    assign w_load        = w_pv && (!r_out_vld || m_axis_tready);
    assign w_now         = s_axis_tdata[63:0];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= 32'd1000;
            r_bucket <= 32'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tbrl_pkg::CFG_RATE:   r_rate   <= i_cfg_wdata;
                tbrl_pkg::CFG_BUCKET: r_bucket <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // last_time only depends on kind and now_us, so track it at the input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
        end else if (w_accept && (s_axis_tuser == tbrl_pkg::KIND_REFILL ||
                                  s_axis_tuser == tbrl_pkg::KIND_INIT)) begin
            r_last_time <= w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_tag.kind  <= s_axis_tuser;
            r_s1_tag.need  <= s_axis_tdata[95:64];
            r_s1_tag.back  <= (w_now < r_last_time);
            r_s1_tag.p_top <= 1'b0;
            r_s1_tag.p_low <= '0;
            r_s1_elapsed   <= w_now - r_last_time;
        end
    end

    tbrl_refill_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (r_s1_vld),
        .i_tag     (r_s1_tag),
        .i_elapsed (r_s1_elapsed),
        .i_rate    (r_rate),
        .o_vld     (w_pv),
        .o_tag     (w_ptag),
        .o_g0      (w_g0),
        .o_g1      (w_g1),
        .o_rem     (w_prem)
    );

    // wrap of product + remainder past 2^64: result is below 10^6, no gain
    assign w_wrap_sum = 21'(w_ptag.p_low) + 21'(r_rem);
    assign w_wrap     = w_ptag.p_top && w_wrap_sum[20];

    assign w_rsum   = 21'(w_prem) + 21'(r_rem);
    assign w_rc     = (w_rsum >= 21'(tbrl_pkg::US_PER_SEC));
    assign w_rem_nw = w_rc ? 20'(w_rsum - 21'(tbrl_pkg::US_PER_SEC)) : w_rsum[19:0];
    assign w_gain   = w_wrap ? 33'd0 : (w_rc ? w_g1 : w_g0);
    assign w_sum    = 34'(r_tokens) + 34'(w_gain);
    assign w_tok_ref = (w_sum > 34'(r_bucket)) ? r_bucket : w_sum[31:0];

    always_comb begin
        n_status = tbrl_pkg::ST_OK;
        n_tokens = r_tokens;
        n_rem    = r_rem;
        unique case (w_ptag.kind)
            tbrl_pkg::KIND_REFILL: begin
                if (w_ptag.back) begin
                    n_status = tbrl_pkg::ST_BACK;
                end else begin
                    n_tokens = w_tok_ref;
                    n_rem    = w_wrap ? w_wrap_sum[19:0] : w_rem_nw;
                end
            end
            tbrl_pkg::KIND_TAKE: begin
                if (r_tokens < w_ptag.need) begin
                    n_status = tbrl_pkg::ST_SHORT;
                end else begin
                    n_tokens = r_tokens - w_ptag.need;
                end
            end
            tbrl_pkg::KIND_INIT: begin
                n_tokens = r_bucket;
                n_rem    = '0;
            end
            default: ;  // unused kind: no change
        endcase
    end

    // bucket state commits as the result enters the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tokens  <= '0;
            r_rem     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_tokens  <= n_tokens;
                r_rem     <= n_rem;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= n_status;
            r_out_tokens <= n_tokens;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_tokens;
    assign m_axis_tuser  = r_out_status;

endmodule

>>> src/tbrl_checker.sv
// Port-level checks for the token bucket rate limiter, bound to the top.
module tbrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an empty output never blocks the request side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == tbrl_pkg::ST_OK ||
                           m_axis_tuser == tbrl_pkg::ST_BACK ||
                           m_axis_tuser == tbrl_pkg::ST_SHORT))
        else $error("undefined status code");

    // register writes land only with both streams quiet
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !s_axis_tvalid && !m_axis_tvalid)
        else $error("register write while busy");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (.*);

>>> tb/tb_token_bucket_rate_limiter.sv
// Self-checking testbench for the token bucket rate limiter: directed cases, random traffic.
`timescale 1ns / 1ps

module tb_token_bucket_rate_limiter;

    localparam logic [1:0] KIND_NOP = 2'd3;  // unused kind, leaves the bucket alone
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        tbrl_pkg::t_status status;
        logic [31:0]       tokens;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // bucket image kept in step with accepted requests
    logic [31:0] cfg_rate;
    logic [31:0] cfg_bucket;
    logic [31:0] bkt_tokens;
    logic [63:0] bkt_last;
    logic [19:0] bkt_rem;

    t_verdict pending_results[$];
    int errors;
    int n_sent;
    int n_ok;
    int n_back;
    int n_short;
    bit src_gaps;
    bit sink_gaps;
    bit hold_req;

    token_bucket_rate_limiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Applies one request to the bucket image and returns the result it must produce.
    function automatic t_verdict bucket_update(input logic [1:0] kind, input logic [63:0] now,
                                               input logic [31:0] need);
        t_verdict    res;
        logic [63:0] acc;
        logic [63:0] sum;
        res.status = tbrl_pkg::ST_OK;
        case (kind)
            tbrl_pkg::KIND_REFILL: begin
                if (now < bkt_last) begin
                    bkt_last   = now;
                    res.status = tbrl_pkg::ST_BACK;
                end else begin
                    // wraps modulo 2^64 on purpose
                    acc      = {32'd0, cfg_rate} * (now - bkt_last) + {44'd0, bkt_rem};
                    sum      = {32'd0, bkt_tokens} + acc / 64'(tbrl_pkg::US_PER_SEC);
                    bkt_rem  = 20'(acc % 64'(tbrl_pkg::US_PER_SEC));
                    bkt_last = now;
                    if (sum > {32'd0, cfg_bucket})
                        sum = {32'd0, cfg_bucket};
                    bkt_tokens = sum[31:0];
                end
            end
            tbrl_pkg::KIND_TAKE: begin
                if (bkt_tokens < need)
                    res.status = tbrl_pkg::ST_SHORT;
                else
                    bkt_tokens = bkt_tokens - need;
            end
            tbrl_pkg::KIND_INIT: begin
                bkt_tokens = cfg_bucket;
                bkt_last   = now;
                bkt_rem    = '0;
            end
            default: ;
        endcase
        res.tokens = bkt_tokens;
        return res;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [63:0] now,
                                input logic [31:0] need);
        int gap;
        int r;
        gap = 0;
        if (src_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 90)
                gap = $urandom_range(10, 40);
            else if (r >= 50)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {need, now};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(bucket_update(kind, now, need));
        n_sent++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Register writes only happen with the pipeline empty.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == tbrl_pkg::CFG_RATE)
            cfg_rate = value;
        else
            cfg_bucket = value;
    endtask

    // Well-formed traffic: time mostly moves forward, takes sized around the count.
    task automatic run_traffic(input int count, input bit do_init);
        logic [63:0] clock_us;
        logic [31:0] need;
        int r;
        int d;
        clock_us = bkt_last;
        if (do_init) begin
            clock_us = {12'd0, 20'($urandom), 32'($urandom)};
            send_request(tbrl_pkg::KIND_INIT, clock_us, $urandom);
        end
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                d = $urandom_range(0, 99);
                if (d < 60)
                    clock_us += 64'($urandom_range(0, 5000));
                else if (d < 85)
                    clock_us += 64'($urandom_range(0, 3000000));
                else if (d < 97)
                    clock_us += 64'($urandom);
                else
                    clock_us += {32'($urandom), 32'($urandom)};
                send_request(tbrl_pkg::KIND_REFILL, clock_us, $urandom);
            end else if (r < 80) begin
                d = $urandom_range(0, 99);
                if (d < 55)
                    need = $urandom_range(0, bkt_tokens);
                else if (d < 85)
                    need = bkt_tokens + 32'($urandom_range(0, 50));
                else
                    need = $urandom;
                send_request(tbrl_pkg::KIND_TAKE, {32'($urandom), 32'($urandom)}, need);
            end else if (r < 88) begin
                clock_us = (clock_us > 64'd1000) ?
                           clock_us - 64'($urandom_range(1, 1000)) : '0;
                send_request(tbrl_pkg::KIND_REFILL, clock_us, $urandom);
            end else if (r < 95) begin
                send_request(tbrl_pkg::KIND_INIT, clock_us, $urandom);
            end else begin
                send_request(KIND_NOP, {32'($urandom), 32'($urandom)}, $urandom);
            end
        end
    endtask

    task automatic test_reset_state();
        send_request(tbrl_pkg::KIND_TAKE, 64'd0, 32'd0);
        send_request(tbrl_pkg::KIND_TAKE, 64'd0, 32'd1);
        send_request(KIND_NOP, 64'd77, 32'd3);
        send_request(tbrl_pkg::KIND_REFILL, 64'd5, 32'd0);
    endtask

    task automatic test_refill_and_take();
        send_request(tbrl_pkg::KIND_INIT, 64'd1000, 32'd0);
        send_request(tbrl_pkg::KIND_TAKE, 64'd0, 32'd999);
        send_request(tbrl_pkg::KIND_TAKE, 64'd0, 32'd2);
        send_request(tbrl_pkg::KIND_REFILL, 64'd3000, 32'd0);
        send_request(tbrl_pkg::KIND_REFILL, 64'd2500, 32'd0);  // time goes backwards
        send_request(tbrl_pkg::KIND_REFILL, 64'd3499, 32'd0);  // remainder just below a token
        send_request(tbrl_pkg::KIND_REFILL, 64'd3500, 32'd0);  // remainder carries into a token
    endtask

    task automatic test_extremes();
        write_reg(tbrl_pkg::CFG_RATE, '1);
        write_reg(tbrl_pkg::CFG_BUCKET, '1);
        send_request(tbrl_pkg::KIND_INIT, 64'd0, 32'd0);
        send_request(tbrl_pkg::KIND_TAKE, 64'd0, '1);
        send_request(tbrl_pkg::KIND_REFILL, '1, 32'd0);        // product wraps, count clamps
        send_request(tbrl_pkg::KIND_REFILL, '1, 32'd0);
        write_reg(tbrl_pkg::CFG_BUCKET, 32'd10);
        send_request(tbrl_pkg::KIND_TAKE, 64'd0, 32'd5);       // take leaves count above bucket
        send_request(tbrl_pkg::KIND_REFILL, '1, 32'd0);        // refill clamps it down
        write_reg(tbrl_pkg::CFG_RATE, 32'd0);
        send_request(tbrl_pkg::KIND_INIT, 64'd100, 32'd0);
        send_request(tbrl_pkg::KIND_REFILL, 64'd1000000000, 32'd0);
        write_reg(tbrl_pkg::CFG_BUCKET, 32'd0);
        send_request(tbrl_pkg::KIND_INIT, 64'd7, '1);
        send_request(tbrl_pkg::KIND_TAKE, '1, 32'd0);
        send_request(tbrl_pkg::KIND_REFILL, 64'd0, 32'd0);
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin
                    write_reg(tbrl_pkg::CFG_RATE, 32'd1000);
                    write_reg(tbrl_pkg::CFG_BUCKET, 32'd1000);
                end
                1: begin
                    write_reg(tbrl_pkg::CFG_RATE, 32'd1);
                    write_reg(tbrl_pkg::CFG_BUCKET, 32'd5);
                end
                2: begin
                    write_reg(tbrl_pkg::CFG_RATE, 32'd1000000);
                    write_reg(tbrl_pkg::CFG_BUCKET, 32'd100);
                end
                3: begin
                    write_reg(tbrl_pkg::CFG_RATE, 32'd999999);
                    write_reg(tbrl_pkg::CFG_BUCKET, 32'd50);
                end
                4: begin
                    write_reg(tbrl_pkg::CFG_RATE, $urandom);
                    write_reg(tbrl_pkg::CFG_BUCKET, $urandom);
                end
                5: begin
                    write_reg(tbrl_pkg::CFG_RATE, '1);
                    write_reg(tbrl_pkg::CFG_BUCKET, $urandom_range(0, 1000));
                end
                6: begin
                    write_reg(tbrl_pkg::CFG_RATE, 32'd0);
                    write_reg(tbrl_pkg::CFG_BUCKET, 32'd1000);
                end
                7: begin
                    write_reg(tbrl_pkg::CFG_RATE, $urandom_range(1, 5000000));
                    write_reg(tbrl_pkg::CFG_BUCKET, '1);
                end
                default: begin
                    write_reg(tbrl_pkg::CFG_RATE, 32'd3000);
                    write_reg(tbrl_pkg::CFG_BUCKET, 32'd0);
                end
            endcase
            run_traffic(75, 1'b1);
        end
        // shrink the bucket under a running count, no init
        write_reg(tbrl_pkg::CFG_RATE, 32'd2000000);
        write_reg(tbrl_pkg::CFG_BUCKET, 32'd100000);
        run_traffic(40, 1'b1);
        write_reg(tbrl_pkg::CFG_BUCKET, 32'd20);
        run_traffic(40, 1'b0);
    endtask

    task automatic test_backpressure();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        write_reg(tbrl_pkg::CFG_RATE, 32'd50000);
        write_reg(tbrl_pkg::CFG_BUCKET, 32'd5000);
        hold_req = 1'b1;
        run_traffic(120, 1'b1);
        wait_for_results();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_noise();
        write_reg(tbrl_pkg::CFG_RATE, $urandom);
        write_reg(tbrl_pkg::CFG_BUCKET, $urandom);
        for (int i = 0; i < 100; i++)
            send_request(2'($urandom_range(0, 3)), {32'($urandom), 32'($urandom)}, $urandom);
    endtask

    // Result side: random stalls, or one long hold-off when asked.
    initial begin : sink
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!sink_gaps) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got status %0d tokens %0d",
                             $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, m_axis_tuser);
                end
                if (m_axis_tdata !== want.tokens) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: tokens_left mismatch, expected %0d, got %0d",
                                 $time, want.tokens, m_axis_tdata);
                end
                case (want.status)
                    tbrl_pkg::ST_BACK:  n_back++;
                    tbrl_pkg::ST_SHORT: n_short++;
                    default:            n_ok++;
                endcase
            end
        end
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_rate      = 32'd1000;
        cfg_bucket    = 32'd1000;
        bkt_tokens    = '0;
        bkt_last      = '0;
        bkt_rem       = '0;
        errors        = 0;
        n_sent        = 0;
        n_ok          = 0;
        n_back        = 0;
        n_short       = 0;
        src_gaps      = 1'b1;
        sink_gaps     = 1'b1;
        hold_req      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_refill_and_take();
        test_extremes();
        test_random_traffic();
        test_backpressure();
        test_noise();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests: corner cases, random traffic under many rate and bucket",
                 n_sent);
        $display("limits, a long receiver stall; %0d ok, %0d time backwards, %0d refused.",
                 n_ok, n_back, n_short);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
